// ===== sv/tsz_pkg.sv =====
// ----------------------------------------------------------------------------
// tsz_pkg: shared types for the zero-sum triplet finder
// Beat payloads, sequencer states and the compare unit interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsz_pkg;

	localparam int DATA_W           = 32;
	localparam int MAX_ELEMS_DEF    = 32;
	localparam int MAX_TRIPLETS_DEF = 64;

	// input beat
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     final_item;
	} item_t;

	// result beat
	typedef struct packed {
		logic signed [DATA_W-1:0] smallest;
		logic signed [DATA_W-1:0] middle;
		logic signed [DATA_W-1:0] largest;
		logic                     triplet_valid;
		logic                     run_end;
		logic                     overflowed;
	} result_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_NEXT,
		ST_SORT_KEY,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_ANC_CHK,
		ST_ANC_LD,
		ST_PAIR_CHK,
		ST_PAIR_EVAL,
		ST_LO_CHK,
		ST_LO_CMP,
		ST_HI_CHK,
		ST_HI_CMP,
		ST_ANC_SKIP,
		ST_ANC_CMP,
		ST_FINISH
	} state_t;

	// shared adder operations
	typedef enum logic {
		ALU_SUB,
		ALU_SUM3
	} alu_op_t;

	// sign of the adder result
	typedef struct packed {
		logic pos;
		logic zero;
	} alu_flags_t;

endpackage

`default_nettype wire

// ===== sv/tsz_mem.sv =====
// ----------------------------------------------------------------------------
// tsz_mem: element store
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsz_mem
	import tsz_pkg::*;
#(
	parameter int DEPTH = MAX_ELEMS_DEF,
	parameter int AW    = $clog2(MAX_ELEMS_DEF)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr_a,
	input  wire logic [AW-1:0]     raddr_b,
	output logic      [DATA_W-1:0] rdata_a,
	output logic      [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_a_q;
	logic [DATA_W-1:0] rdata_b_q;

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

// ===== sv/tsz_alu.sv =====
// ----------------------------------------------------------------------------
// tsz_alu: shared compare adder
// Forms x - y or x + y + z in 34 bits and reports the sign of the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsz_alu
	import tsz_pkg::*;
(
	input  wire alu_op_t           op,
	input  wire logic [DATA_W-1:0] x,
	input  wire logic [DATA_W-1:0] y,
	input  wire logic [DATA_W-1:0] z,
	output alu_flags_t             flags
);

	localparam int SW = DATA_W + 2;

	logic [SW-1:0] x_ext;
	logic [SW-1:0] y_ext;
	logic [SW-1:0] z_ext;
	logic [SW-1:0] y_op;
	logic [SW-1:0] z_op;
	logic [SW-1:0] sum;

	// sign extension, three operands cannot overflow 34 bits
	assign x_ext = {{2{x[DATA_W-1]}}, x};
	assign y_ext = {{2{y[DATA_W-1]}}, y};
	assign z_ext = {{2{z[DATA_W-1]}}, z};

	always_comb begin
		case (op)
			ALU_SUB: begin
				y_op = ~y_ext + SW'(1);
				z_op = '0;
			end
			ALU_SUM3: begin
				y_op = y_ext;
				z_op = z_ext;
			end
			default: begin
				y_op = y_ext;
				z_op = '0;
			end
		endcase
	end

	assign sum        = x_ext + y_op + z_op;
	assign flags.zero = (sum == '0);
	assign flags.pos  = !sum[SW-1] && (sum != '0);

endmodule

`default_nettype wire

// ===== sv/tsz_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsz_ctrl: load, sort and search sequencer
// Loads the set, insertion-sorts it in place, then walks anchor and
// two-pointer search with one compare per step, holding one found triplet
// back so the last one can carry the end and overflow flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsz_ctrl
	import tsz_pkg::*;
#(
	parameter int MAX_ELEMS    = MAX_ELEMS_DEF,
	parameter int MAX_TRIPLETS = MAX_TRIPLETS_DEF,
	parameter int AW           = $clog2(MAX_ELEMS_DEF)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire item_t             item,
	output logic                   busy,
	output logic                   emit_v,
	output result_t                emit_data,
	output logic                   mem_we,
	output logic      [AW-1:0]     mem_waddr,
	output logic      [DATA_W-1:0] mem_wdata,
	output logic      [AW-1:0]     mem_raddr_a,
	output logic      [AW-1:0]     mem_raddr_b,
	input  wire logic [DATA_W-1:0] mem_rdata_a,
	input  wire logic [DATA_W-1:0] mem_rdata_b,
	output alu_op_t                alu_op,
	output logic      [DATA_W-1:0] alu_x,
	output logic      [DATA_W-1:0] alu_y,
	output logic      [DATA_W-1:0] alu_z,
	input  wire alu_flags_t        alu_flags
);

	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int TW = $clog2(MAX_TRIPLETS + 1);

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] i_q, i_d;
	logic [AW-1:0] j_q, j_d;
	logic [CW-1:0] anc_q, anc_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [TW-1:0] emitted_q, emitted_d;
	logic          more_q, more_d;
	logic          pend_v_q, pend_v_d;

	logic [DATA_W-1:0] key_q, key_d;
	logic [DATA_W-1:0] anc_val_q, anc_val_d;
	logic [DATA_W-1:0] lo_val_q, lo_val_d;
	logic [DATA_W-1:0] hi_val_q, hi_val_d;
	logic [DATA_W-1:0] pend_lo_q, pend_lo_d;
	logic [DATA_W-1:0] pend_hi_q, pend_hi_d;
	logic [DATA_W-1:0] pend_anc_q, pend_anc_d;

	logic [CW-1:0] i_m1;
	logic [CW-1:0] lo_p1;
	logic [CW-1:0] hi_m1;
	logic [CW-1:0] anc_p1;
	logic [CW:0]   anc_p2_w;
	logic [CW:0]   anc_p1_w;
	logic [AW-1:0] j_p1;
	logic [AW-1:0] j_m1;

	// pointer neighbors
	assign i_m1     = i_q - CW'(1);
	assign lo_p1    = lo_q + CW'(1);
	assign hi_m1    = hi_q - CW'(1);
	assign anc_p1   = anc_q + CW'(1);
	assign anc_p2_w = {1'b0, anc_q} + (CW+1)'(2);
	assign anc_p1_w = {1'b0, anc_q} + (CW+1)'(1);
	assign j_p1     = j_q + AW'(1);
	assign j_m1     = j_q - AW'(1);

	assign busy = (state_q != ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			anc_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			emitted_q <= '0;
			more_q    <= 1'b0;
			pend_v_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			i_q       <= i_d;
			j_q       <= j_d;
			anc_q     <= anc_d;
			lo_q      <= lo_d;
			hi_q      <= hi_d;
			emitted_q <= emitted_d;
			more_q    <= more_d;
			pend_v_q  <= pend_v_d;
		end
	end

	// value registers
	always_ff @(posedge clk) begin
		key_q      <= key_d;
		anc_val_q  <= anc_val_d;
		lo_val_q   <= lo_val_d;
		hi_val_q   <= hi_val_d;
		pend_lo_q  <= pend_lo_d;
		pend_hi_q  <= pend_hi_d;
		pend_anc_q <= pend_anc_d;
	end

	// next state and outputs
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		i_d        = i_q;
		j_d        = j_q;
		anc_d      = anc_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		emitted_d  = emitted_q;
		more_d     = more_q;
		pend_v_d   = pend_v_q;
		key_d      = key_q;
		anc_val_d  = anc_val_q;
		lo_val_d   = lo_val_q;
		hi_val_d   = hi_val_q;
		pend_lo_d  = pend_lo_q;
		pend_hi_d  = pend_hi_q;
		pend_anc_d = pend_anc_q;

		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = item.value;
		mem_raddr_a = '0;
		mem_raddr_b = '0;

		alu_op = ALU_SUB;
		alu_x  = mem_rdata_a;
		alu_y  = key_q;
		alu_z  = '0;

		emit_v                  = 1'b0;
		emit_data.smallest      = pend_anc_q;
		emit_data.middle        = pend_lo_q;
		emit_data.largest       = pend_hi_q;
		emit_data.triplet_valid = 1'b1;
		emit_data.run_end       = 1'b0;
		emit_data.overflowed    = 1'b0;

		case (state_q)
			// load beats, drop values once the store is full
			ST_IDLE: begin
				if (start) begin
					if (cnt_q < CW'(MAX_ELEMS)) begin
						mem_we    = 1'b1;
						mem_waddr = cnt_q[AW-1:0];
						cnt_d     = cnt_q + CW'(1);
					end
					if (item.final_item) begin
						i_d       = CW'(1);
						anc_d     = '0;
						emitted_d = '0;
						more_d    = 1'b0;
						pend_v_d  = 1'b0;
						state_d   = ST_SORT_NEXT;
					end
				end
			end

			// insertion sort: fetch the next key
			ST_SORT_NEXT: begin
				if (i_q < cnt_q) begin
					mem_raddr_a = i_q[AW-1:0];
					state_d     = ST_SORT_KEY;
				end else begin
					state_d = ST_ANC_CHK;
				end
			end

			ST_SORT_KEY: begin
				key_d       = mem_rdata_a;
				j_d         = i_m1[AW-1:0];
				mem_raddr_a = i_m1[AW-1:0];
				state_d     = ST_SORT_CMP;
			end

			// shift larger values up one place
			ST_SORT_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = j_p1;
				if (alu_flags.pos) begin
					mem_wdata = mem_rdata_a;
					if (j_q == '0) begin
						state_d = ST_SORT_PUT;
					end else begin
						j_d         = j_m1;
						mem_raddr_a = j_m1;
					end
				end else begin
					mem_wdata = key_q;
					i_d       = i_q + CW'(1);
					state_d   = ST_SORT_NEXT;
				end
			end

			ST_SORT_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = key_q;
				i_d       = i_q + CW'(1);
				state_d   = ST_SORT_NEXT;
			end

			// next anchor while at least two values remain to its right
			ST_ANC_CHK: begin
				if (anc_p2_w < {1'b0, cnt_q}) begin
					mem_raddr_a = anc_q[AW-1:0];
					state_d     = ST_ANC_LD;
				end else begin
					state_d = ST_FINISH;
				end
			end

			ST_ANC_LD: begin
				anc_val_d = mem_rdata_a;
				lo_d      = anc_p1;
				hi_d      = cnt_q - CW'(1);
				state_d   = ST_PAIR_CHK;
			end

			// two-pointer step
			ST_PAIR_CHK: begin
				if (lo_q < hi_q) begin
					mem_raddr_a = lo_q[AW-1:0];
					mem_raddr_b = hi_q[AW-1:0];
					state_d     = ST_PAIR_EVAL;
				end else begin
					state_d = ST_ANC_SKIP;
				end
			end

			ST_PAIR_EVAL: begin
				alu_op = ALU_SUM3;
				alu_x  = anc_val_q;
				alu_y  = mem_rdata_a;
				alu_z  = mem_rdata_b;
				if (alu_flags.pos) begin
					hi_d    = hi_m1;
					state_d = ST_PAIR_CHK;
				end else if (!alu_flags.zero) begin
					lo_d    = lo_p1;
					state_d = ST_PAIR_CHK;
				end else if (emitted_q == TW'(MAX_TRIPLETS)) begin
					more_d  = 1'b1;
					state_d = ST_FINISH;
				end else begin
					// release the held triplet, hold the new one
					emit_v     = pend_v_q;
					pend_v_d   = 1'b1;
					pend_anc_d = anc_val_q;
					pend_lo_d  = mem_rdata_a;
					pend_hi_d  = mem_rdata_b;
					lo_val_d   = mem_rdata_a;
					hi_val_d   = mem_rdata_b;
					emitted_d  = emitted_q + TW'(1);
					state_d    = ST_LO_CHK;
				end
			end

			// skip repeats of the low value
			ST_LO_CHK: begin
				if (lo_q < hi_q) begin
					mem_raddr_a = lo_p1[AW-1:0];
					state_d     = ST_LO_CMP;
				end else begin
					lo_d    = lo_p1;
					state_d = ST_HI_CHK;
				end
			end

			ST_LO_CMP: begin
				alu_y = lo_val_q;
				lo_d  = lo_p1;
				if (alu_flags.zero) begin
					state_d = ST_LO_CHK;
				end else begin
					state_d = ST_HI_CHK;
				end
			end

			// skip repeats of the high value
			ST_HI_CHK: begin
				if (lo_q < hi_q) begin
					mem_raddr_a = hi_m1[AW-1:0];
					state_d     = ST_HI_CMP;
				end else begin
					hi_d    = hi_m1;
					state_d = ST_PAIR_CHK;
				end
			end

			ST_HI_CMP: begin
				alu_y = hi_val_q;
				hi_d  = hi_m1;
				if (alu_flags.zero) begin
					state_d = ST_HI_CHK;
				end else begin
					state_d = ST_PAIR_CHK;
				end
			end

			// skip repeats of the anchor value
			ST_ANC_SKIP: begin
				if (anc_p1_w < {1'b0, cnt_q}) begin
					mem_raddr_a = anc_p1[AW-1:0];
					state_d     = ST_ANC_CMP;
				end else begin
					anc_d   = anc_p1;
					state_d = ST_ANC_CHK;
				end
			end

			ST_ANC_CMP: begin
				alu_y = anc_val_q;
				anc_d = anc_p1;
				if (alu_flags.zero) begin
					state_d = ST_ANC_SKIP;
				end else begin
					state_d = ST_ANC_CHK;
				end
			end

			// last beat: held triplet or empty done
			ST_FINISH: begin
				emit_v            = 1'b1;
				emit_data.run_end = 1'b1;
				if (pend_v_q) begin
					emit_data.overflowed = more_q;
				end else begin
					emit_data.smallest      = '0;
					emit_data.middle        = '0;
					emit_data.largest       = '0;
					emit_data.triplet_valid = 1'b0;
				end
				cnt_d   = '0;
				anc_d   = '0;
				lo_d    = '0;
				hi_d    = '0;
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/three_sum_zero_triplets_top.sv =====
// ----------------------------------------------------------------------------
// three_sum_zero_triplets_top: zero-sum triplet finder
// Loads a set of signed values, sorts it and reports the distinct triplets
// that sum to zero, ascending by anchor then middle value, up to the triplet limit.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   -------   -----------------------   --------------------------------
//   input     start & !busy             item   (value, final_item)
//   result    strobe, one cycle         result (triplet, end, overflow)
//
// a beat that is not final is loaded and leaves busy low. the final beat
// starts sort and search, both on one shared 34-bit adder and one
// two-read-port store.
// reset clears the sequencer and the fill count; the store needs no clearing.
// results are strobed for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_sum_zero_triplets_top
	import tsz_pkg::*;
#(
	parameter int MAX_ELEMS    = MAX_ELEMS_DEF,
	parameter int MAX_TRIPLETS = MAX_TRIPLETS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       strobe,
	output result_t    result
);

	localparam int AW = $clog2(MAX_ELEMS);

	logic              emit_v;
	result_t           emit_data;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr_a;
	logic [AW-1:0]     mem_raddr_b;
	logic [DATA_W-1:0] mem_rdata_a;
	logic [DATA_W-1:0] mem_rdata_b;
	alu_op_t           alu_op;
	logic [DATA_W-1:0] alu_x;
	logic [DATA_W-1:0] alu_y;
	logic [DATA_W-1:0] alu_z;
	alu_flags_t        alu_flags;

	logic    strobe_q;
	result_t result_q;

	// sequencer
	tsz_ctrl #(
		.MAX_ELEMS    (MAX_ELEMS),
		.MAX_TRIPLETS (MAX_TRIPLETS),
		.AW           (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.busy        (busy),
		.emit_v      (emit_v),
		.emit_data   (emit_data),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b),
		.alu_op      (alu_op),
		.alu_x       (alu_x),
		.alu_y       (alu_y),
		.alu_z       (alu_z),
		.alu_flags   (alu_flags)
	);

	// element store
	tsz_mem #(
		.DEPTH (MAX_ELEMS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	// shared compare adder
	tsz_alu u_alu (
		.op    (alu_op),
		.x     (alu_x),
		.y     (alu_y),
		.z     (alu_z),
		.flags (alu_flags)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_v;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v) begin
			result_q <= emit_data;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== tb/tsz_triplet_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsz_triplet_checker: result checker for the zero-sum triplet finder
// Watches the input and result channels. On every final beat it sorts the
// loaded set, runs the anchor and two-pointer search itself and queues the
// triplets it expects. Each strobed result is compared field by field with
// the oldest queued triplet.
// ----------------------------------------------------------------------------

module tsz_triplet_checker
	import tsz_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    busy,
	input  wire item_t   item,
	input  wire logic    strobe,
	input  wire result_t result,
	output int           mismatch_count,
	output int           outstanding,
	output int           beat_count,
	output int           set_count,
	output int           triplet_count,
	output int           empty_runs,
	output int           truncated_runs,
	output int           overfull_sets
);

	localparam int STORE_DEPTH = MAX_ELEMS_DEF;
	localparam int TRIPLET_CAP = MAX_TRIPLETS_DEF;

	logic signed [DATA_W-1:0] loaded_vals [STORE_DEPTH];
	int                       fill;
	bit                       values_dropped;
	result_t                  pending_triplets [$];
	result_t                  expected_beat;
	bit                       field_bad;

	// sort the loaded set and queue every distinct zero-sum triplet
	function automatic void find_zero_triplets();
		longint  sorted_vals [STORE_DEPTH];
		result_t found [$];
		result_t r;
		longint  key, target, pair_sum;
		int      n, i, j, anchor, lo, hi;
		bit      truncated;
		n = fill;
		truncated = 1'b0;
		for (i = 0; i < n; i++)
			sorted_vals[i] = longint'(loaded_vals[i]);
		// insertion sort, ascending
		for (i = 1; i < n; i++) begin
			key = sorted_vals[i];
			j = i - 1;
			while (j >= 0 && sorted_vals[j] > key) begin
				sorted_vals[j + 1] = sorted_vals[j];
				j--;
			end
			sorted_vals[j + 1] = key;
		end
		// one anchor per distinct value, pair scan to its right
		anchor = 0;
		while (anchor + 2 < n && !truncated) begin
			target = -sorted_vals[anchor];
			lo = anchor + 1;
			hi = n - 1;
			while (lo < hi && !truncated) begin
				pair_sum = sorted_vals[lo] + sorted_vals[hi];
				if (pair_sum > target) begin
					hi--;
				end else if (pair_sum < target) begin
					lo++;
				end else if (found.size() >= TRIPLET_CAP) begin
					truncated = 1'b1;
				end else begin
					r = '0;
					r.smallest      = 32'(sorted_vals[anchor]);
					r.middle        = 32'(sorted_vals[lo]);
					r.largest       = 32'(sorted_vals[hi]);
					r.triplet_valid = 1'b1;
					found = {found, r};
					while (lo < hi && sorted_vals[lo] == sorted_vals[lo + 1])
						lo++;
					lo++;
					while (lo < hi && sorted_vals[hi] == sorted_vals[hi - 1])
						hi--;
					hi--;
				end
			end
			while (anchor + 1 < n && sorted_vals[anchor] == sorted_vals[anchor + 1])
				anchor++;
			anchor++;
		end
		// last beat carries the end and overflow marks
		if (found.size() == 0) begin
			r = '0;
			r.run_end = 1'b1;
			found = {found, r};
			empty_runs++;
		end else begin
			r = found.pop_back();
			r.run_end    = 1'b1;
			r.overflowed = truncated;
			found = {found, r};
			if (truncated)
				truncated_runs++;
		end
		foreach (found[k])
			pending_triplets = {pending_triplets, found[k]};
	endfunction

	// channel monitor: results first, then the input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_triplets.delete();
			fill           = 0;
			values_dropped = 1'b0;
			mismatch_count = 0;
			outstanding    = 0;
			beat_count     = 0;
			set_count      = 0;
			triplet_count  = 0;
			empty_runs     = 0;
			truncated_runs = 0;
			overfull_sets  = 0;
		end else begin
			if (strobe) begin
				if (pending_triplets.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with none expected: %0d %0d %0d valid=%0b end=%0b ovf=%0b",
							$time, result.smallest, result.middle, result.largest,
							result.triplet_valid, result.run_end, result.overflowed);
				end else begin
					expected_beat = pending_triplets.pop_front();
					field_bad = (result.smallest !== expected_beat.smallest)
						|| (result.middle !== expected_beat.middle)
						|| (result.largest !== expected_beat.largest)
						|| (result.triplet_valid !== expected_beat.triplet_valid)
						|| (result.run_end !== expected_beat.run_end)
						|| (result.overflowed !== expected_beat.overflowed);
					if (field_bad) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: expected %0d %0d %0d valid=%0b end=%0b ovf=%0b",
								$time, expected_beat.smallest, expected_beat.middle,
								expected_beat.largest, expected_beat.triplet_valid,
								expected_beat.run_end, expected_beat.overflowed);
							$display("%0t: actual   %0d %0d %0d valid=%0b end=%0b ovf=%0b",
								$time, result.smallest, result.middle, result.largest,
								result.triplet_valid, result.run_end, result.overflowed);
						end
					end
					if (expected_beat.triplet_valid)
						triplet_count++;
				end
			end
			if (start && !busy) begin
				beat_count++;
				// values past the store depth are dropped
				if (fill < STORE_DEPTH) begin
					loaded_vals[fill] = item.value;
					fill++;
				end else begin
					values_dropped = 1'b1;
				end
				if (item.final_item) begin
					set_count++;
					if (values_dropped)
						overfull_sets++;
					find_zero_triplets();
					fill           = 0;
					values_dropped = 1'b0;
				end
			end
			outstanding = pending_triplets.size();
		end
	end

endmodule

// ===== tb/tb_three_sum_zero_triplets_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_sum_zero_triplets_top: testbench for the zero-sum triplet finder
// Loads directed sets (too few values, no triplet, extreme values, wide sums,
// duplicates), then random sets: dense small-range sets rich in triplets,
// sets built from wide zero-sum triplets, noise, and big sets that may overrun
// the store and the triplet limit. The side checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_three_sum_zero_triplets_top;
	import tsz_pkg::*;

	localparam int                       BEAT_TARGET = 330;
	localparam int                       IDLE_PCT    = 38;
	localparam logic signed [DATA_W-1:0] VAL_MIN     = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX     = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] VAL_HALF    = 32'sh4000_0000;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    strobe;
	result_t result;

	int mismatch_count, outstanding, beat_count, set_count;
	int triplet_count, empty_runs, truncated_runs, overfull_sets;

	logic signed [DATA_W-1:0] set_vals [$];
	logic signed [DATA_W-1:0] swap_val;
	int     beats_sent, idle_pct, set_idx, kind, set_size, spread, n_triples, i, j;
	int     a_val, b_val;
	longint c_val;

	three_sum_zero_triplets_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	tsz_triplet_checker triplet_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item),
		.strobe         (strobe),
		.result         (result),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.beat_count     (beat_count),
		.set_count      (set_count),
		.triplet_count  (triplet_count),
		.empty_runs     (empty_runs),
		.truncated_runs (truncated_runs),
		.overfull_sets  (overfull_sets)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("three_sum_zero_triplets_top: mismatch");
		$finish;
	end

	// one input beat, each cycle ahead of it idle at the idle chance
	task automatic load_beat(input logic signed [DATA_W-1:0] v, input logic fin);
		item_t beat;
		beat.value      = v;
		beat.final_item = fin;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= beat;
		do @(posedge clk); while (busy);
		@(negedge clk);
		beats_sent++;
	endtask

	// whole set, final mark on the last value
	task automatic load_set();
		int k;
		for (k = 0; k < set_vals.size(); k++)
			load_beat(set_vals[k], k == set_vals.size() - 1);
	endtask

	// hold off until the block is idle and all triplets are in
	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	// stimulus
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		idle_pct   = IDLE_PCT;
		beats_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: one value, two values, no triplet
		set_vals = '{32'sd5};
		load_set();
		set_vals = '{-32'sd7, 32'sd7};
		load_set();
		set_vals = '{32'sd1, 32'sd2, 32'sd3};
		load_set();
		// extremes and sums that only fit in wide arithmetic
		set_vals = '{VAL_MIN, VAL_MAX, 32'sd1};
		load_set();
		set_vals = '{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_HALF, VAL_HALF};
		load_set();
		// duplicates
		set_vals = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
		load_set();
		set_vals = '{-32'sd1, -32'sd1, 32'sd2, 32'sd2, 32'sd0, 32'sd1, -32'sd1};
		load_set();
		wait_drained();

		// random sets
		set_idx = 0;
		while (beats_sent < BEAT_TARGET) begin
			idle_pct = (set_idx >= 12 && set_idx < 20) ? 0 : IDLE_PCT;
			set_vals.delete();
			kind = (set_idx == 0) ? 0 : $urandom_range(99);
			if (kind < 8) begin
				// large dense set: may overrun the store and the triplet limit
				set_size = $urandom_range(28, 36);
				spread   = (set_idx == 0) ? 16 : $urandom_range(8, 20);
				for (i = 0; i < set_size; i++)
					set_vals = {set_vals, int'($urandom_range(0, 2 * spread)) - spread};
			end else if (kind < 50) begin
				// small dense set with many duplicates
				set_size = $urandom_range(3, 10);
				spread   = $urandom_range(1, 6);
				for (i = 0; i < set_size; i++)
					set_vals = {set_vals, int'($urandom_range(0, 2 * spread)) - spread};
			end else if (kind < 75) begin
				// wide zero-sum triplets plus a few random values, shuffled
				n_triples = $urandom_range(1, 3);
				for (i = 0; i < n_triples; i++) begin
					a_val = int'($urandom) >>> 1;
					b_val = int'($urandom) >>> 1;
					c_val = -(longint'(a_val) + longint'(b_val));
					if (c_val > longint'(VAL_MAX))
						c_val = longint'(VAL_MIN);
					set_vals = {set_vals, a_val};
					set_vals = {set_vals, b_val};
					set_vals = {set_vals, 32'(c_val)};
				end
				set_size = $urandom_range(0, 3);
				for (i = 0; i < set_size; i++)
					set_vals = {set_vals, $urandom};
				for (i = set_vals.size() - 1; i > 0; i--) begin
					j = $urandom_range(i);
					swap_val    = set_vals[i];
					set_vals[i] = set_vals[j];
					set_vals[j] = swap_val;
				end
			end else begin
				// noise: full-range values and extremes, short sets too
				set_size = $urandom_range(1, 8);
				for (i = 0; i < set_size; i++) begin
					case ($urandom_range(7))
						0:       set_vals = {set_vals, VAL_MIN};
						1:       set_vals = {set_vals, VAL_MAX};
						2:       set_vals = {set_vals, -32'sd1};
						default: set_vals = {set_vals, $urandom};
					endcase
				end
			end
			load_set();
			if (set_idx == 25)
				wait_drained();
			set_idx++;
		end

		// drain and let the block settle
		wait_drained();
		repeat (100) @(negedge clk);

		$display("run covered %0d beats in %0d sets, %0d triplets checked, %0d empty runs",
			beat_count, set_count, triplet_count, empty_runs);
		$display("%0d runs cut at the triplet limit, %0d sets loaded past store depth",
			truncated_runs, overfull_sets);
		if (mismatch_count == 0 && outstanding == 0)
			$display("three_sum_zero_triplets_top: match");
		else
			$display("three_sum_zero_triplets_top: mismatch");
		$finish;
	end

endmodule
